// ----- hdl/spins_pkg.sv -----
// Shared types, constants and a helper function for the stream pattern insert block.
package spins_pkg;

  // Default sizes of the window and of the insert table.
  localparam int PATTERN_MAX_DEF = 16;
  localparam int INSERT_MAX_DEF  = 32;

  // Bytes covered by the configuration registers.
  localparam int PATTERN_REG_BYTES = 16;
  localparam int INSERT_REG_BYTES  = 32;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_LOW    = 3'd1,
    REG_PATTERN_HIGH   = 3'd2,
    REG_INSERT_LENGTH  = 3'd3,
    REG_INSERT_WORD_0  = 3'd4,
    REG_INSERT_WORD_1  = 3'd5,
    REG_INSERT_WORD_2  = 3'd6,
    REG_INSERT_WORD_3  = 3'd7
  } cfg_reg_t;

  // One accepted input byte together with its match decision.
  typedef struct packed {
    logic       hit;
    logic [7:0] data;
  } item_t;

  // ASCII case folding: upper-case letters map to lower case.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- hdl/spins_if.sv -----
// Stream interfaces for the input bytes and the edited output bytes.
interface spins_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface spins_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- hdl/stream_pattern_insert.sv -----
// Top level: byte window of chained cells, pattern match and a single insertion.
//
//   channel | direction | handshake          | payload
//   rx      | in        | valid / ready      | data_byte[7:0]
//   tx      | out       | valid / ready      | out_byte[7:0], run_last
//   cfg     | in        | cfg_write          | cfg_index[2:0], cfg_data[63:0]
//
// One item is accepted per cycle while no insertion is running and the output register is free or being drained.
// The match is decided in the accept cycle across all window cells at once.
// After the first match the input stalls while the insert bytes leave one per
// cycle when the output is ready; output back pressure lengthens the stall.
// Reset is synchronous; there is no clearing pass.
module stream_pattern_insert #(
  parameter int PATTERN_MAX = spins_pkg::PATTERN_MAX_DEF,
  parameter int INSERT_MAX  = spins_pkg::INSERT_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  spins_in_if.sink                         rx,
  spins_out_if.source                      tx,
  input  logic                             cfg_write,
  input  logic [spins_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spins_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PLW = $clog2(PATTERN_MAX + 1);
  localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int ILW = $clog2(INSERT_MAX + 1);

  // Configuration registers.
  logic [4:0]                          pattern_length;
  logic [spins_pkg::CFG_DATA_W-1:0]    pattern_low;
  logic [spins_pkg::CFG_DATA_W-1:0]    pattern_high;
  logic [5:0]                          insert_length;
  logic [3:0][spins_pkg::CFG_DATA_W-1:0] insert_word;

  // Block state.
  logic [PLW-1:0] bytes_seen;
  logic           insertion_done;

  logic [PLW-1:0]                 plen;
  logic [ILW-1:0]                 ilen;
  logic [PLW-1:0]                 seen_next;
  logic [PATTERN_MAX-1:0][7:0]    pat_bytes;
  logic [INSERT_MAX-1:0][7:0]     ins_bytes;
  logic [PATTERN_MAX-1:0][7:0]    win;
  logic [PATTERN_MAX-1:0]         cell_hit;
  logic                           accept;
  logic                           free;
  logic                           hit;
  spins_pkg::item_t               item;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_low    <= '0;
      pattern_high   <= '0;
      insert_length  <= '0;
      insert_word    <= '0;
    end else if (cfg_write) begin
      unique case (spins_pkg::cfg_reg_t'(cfg_index))
        spins_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        spins_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        spins_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        spins_pkg::REG_INSERT_LENGTH:  insert_length  <= cfg_data[5:0];
        spins_pkg::REG_INSERT_WORD_0:  insert_word[0] <= cfg_data;
        spins_pkg::REG_INSERT_WORD_1:  insert_word[1] <= cfg_data;
        spins_pkg::REG_INSERT_WORD_2:  insert_word[2] <= cfg_data;
        spins_pkg::REG_INSERT_WORD_3:  insert_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lengths clipped to the sizes of the window and the insert table.
  assign plen = ({3'b000, pattern_length} > 8'(PATTERN_MAX)) ?
                PLW'(PATTERN_MAX) : PLW'(pattern_length);
  assign ilen = ({2'b00, insert_length} > 8'(INSERT_MAX)) ?
                ILW'(INSERT_MAX) : ILW'(insert_length);

  // Byte tables; bytes beyond the registers read as zero.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    if (k < 8) begin : g_low
      assign pat_bytes[k] = pattern_low[8*k +: 8];
    end else if (k < spins_pkg::PATTERN_REG_BYTES) begin : g_high
      assign pat_bytes[k] = pattern_high[8*(k-8) +: 8];
    end else begin : g_zero
      assign pat_bytes[k] = 8'h00;
    end
  end

  for (genvar k = 0; k < INSERT_MAX; k++) begin : g_ins
    if (k < spins_pkg::INSERT_REG_BYTES) begin : g_word
      assign ins_bytes[k] = insert_word[k/8][8*(k%8) +: 8];
    end else begin : g_zero
      assign ins_bytes[k] = 8'h00;
    end
  end

  assign accept = rx.valid && free;

  // Window: cell 0 takes the new byte, every other cell takes its neighbor's byte.
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [7:0] d_in;
    logic [7:0] diff;
    logic       in_use;

    if (j == 0) begin : g_head
      assign d_in = rx.data_byte;
    end else begin : g_link
      assign d_in = win[j-1];
    end

    // Cell j compares the byte entering it with pattern byte plen - 1 - j.
    assign in_use = 8'(j) < 8'(plen);
    assign diff   = 8'(plen) - 8'(j) - 8'd1;

    spins_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .d_in     (d_in),
      .pat_byte (pat_bytes[diff[PIW-1:0]]),
      .in_use   (in_use),
      .q        (win[j]),
      .hit      (cell_hit[j])
    );
  end

  // Match decision for the byte being accepted.
  assign seen_next = (bytes_seen == PLW'(PATTERN_MAX)) ? bytes_seen : bytes_seen + PLW'(1);
  assign hit = !insertion_done && plen != '0 && seen_next >= plen && (&cell_hit);

  // History count and the one-shot insertion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      insertion_done <= 1'b0;
    end else if (accept) begin
      bytes_seen <= seen_next;
      if (hit) begin
        insertion_done <= 1'b1;
      end
    end
  end

  assign item.hit  = hit;
  assign item.data = rx.data_byte;
  assign rx.ready  = free;

  spins_emit #(
    .INSERT_MAX (INSERT_MAX)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .take      (accept),
    .item      (item),
    .ilen      (ilen),
    .ins_bytes (ins_bytes),
    .free      (free),
    .tx        (tx)
  );

endmodule

// ----- hdl/spins_cell.sv -----
// One window cell: holds a byte, passes it on, and compares the incoming byte.
module spins_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d_in,
  input  logic [7:0] pat_byte,
  input  logic       in_use,
  output logic [7:0] q,
  output logic       hit
);

  // The byte moves one place along the window on every accepted item.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d_in;
    end
  end

  // Compare the byte entering this cell; unused cells always agree.
  assign hit = !in_use ||
               (spins_pkg::fold_case(d_in) == spins_pkg::fold_case(pat_byte));

endmodule

// ----- hdl/spins_emit.sv -----
// Output register and insert sequencer: emits the passed byte, then the insert bytes.
module spins_emit #(
  parameter int INSERT_MAX = spins_pkg::INSERT_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  spins_pkg::item_t           item,
  input  logic [$clog2(INSERT_MAX+1)-1:0] ilen,
  input  logic [INSERT_MAX-1:0][7:0] ins_bytes,
  output logic                       free,
  spins_out_if.source                tx
);

  localparam int ILW = $clog2(INSERT_MAX + 1);
  localparam int IIW = (INSERT_MAX > 1) ? $clog2(INSERT_MAX) : 1;

  logic           ovalid;
  logic [7:0]     obyte;
  logic           olast;
  logic           busy;
  logic [ILW-1:0] idx;
  logic           can_load;
  logic           ins_last;

  assign can_load = !ovalid || tx.ready;
  assign free     = !busy && can_load;
  assign ins_last = (idx + ILW'(1)) == ilen;

  // Control: output valid, insertion in progress and the insert position.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      busy   <= 1'b0;
      idx    <= '0;
    end else if (take) begin
      ovalid <= 1'b1;
      if (item.hit && ilen != '0) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end else if (busy && can_load) begin
      ovalid <= 1'b1;
      idx    <= idx + ILW'(1);
      if (ins_last) begin
        busy <= 1'b0;
      end
    end else if (tx.ready) begin
      ovalid <= 1'b0;
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk) begin
    if (take) begin
      obyte <= item.data;
      olast <= !item.hit || ilen == '0;
    end else if (busy && can_load) begin
      obyte <= ins_bytes[idx[IIW-1:0]];
      olast <= ins_last;
    end
  end

  assign tx.valid    = ovalid;
  assign tx.out_byte = obyte;
  assign tx.run_last = olast;

endmodule

// ----- dv/spins_tb_pkg.sv -----
// Scoreboard class that predicts and checks the edited byte stream.
package spins_tb_pkg;

  localparam int WINDOW_BYTES = 16;
  localparam int INSERT_BYTES = 32;

  // One byte of the edited stream as it should leave the block.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } edit_out_t;

  // Upper-case ASCII letters fold to lower case; every other byte stays.
  function automatic logic [7:0] ascii_lower(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return ascii_lower(c) >= 8'h61 && ascii_lower(c) <= 8'h7A;
  endfunction

  class edit_checker;
    int unsigned pat_len;
    logic [7:0]  pat [WINDOW_BYTES];
    int unsigned ins_len;
    logic [7:0]  ins [INSERT_BYTES];
    logic [7:0]  window [WINDOW_BYTES];
    int unsigned seen;
    bit          inserted;
    edit_out_t   due [$];
    int          errors;

    function new();
      pat_len  = 0;
      ins_len  = 0;
      seen     = 0;
      inserted = 1'b0;
      errors   = 0;
      foreach (pat[i]) pat[i] = '0;
      foreach (ins[i]) ins[i] = '0;
      foreach (window[i]) window[i] = '0;
    endfunction

    // Mirror of one register write.
    function void set_reg(spins_pkg::cfg_reg_t idx, logic [63:0] v);
      int base;
      int k;
      case (idx)
        spins_pkg::REG_PATTERN_LENGTH: pat_len = 32'(v[4:0]);
        spins_pkg::REG_PATTERN_LOW: begin
          for (k = 0; k < 8; k++) pat[k] = v[8*k +: 8];
        end
        spins_pkg::REG_PATTERN_HIGH: begin
          for (k = 0; k < 8; k++) pat[8 + k] = v[8*k +: 8];
        end
        spins_pkg::REG_INSERT_LENGTH: ins_len = 32'(v[5:0]);
        default: begin
          base = 8 * (int'(idx) - int'(spins_pkg::REG_INSERT_WORD_0));
          for (k = 0; k < 8; k++) ins[base + k] = v[8*k +: 8];
        end
      endcase
    endfunction

    // Would this byte complete the pattern, given the current window?
    function bit hit_with(logic [7:0] b);
      int plen;
      int filled;
      int k;
      int j;
      logic [7:0] c;
      plen   = (pat_len > WINDOW_BYTES) ? WINDOW_BYTES : pat_len;
      filled = (seen < WINDOW_BYTES) ? seen + 1 : WINDOW_BYTES;
      if (inserted || plen == 0 || filled < plen) begin
        return 1'b0;
      end
      // Pattern byte 0 lines up with the oldest of the newest plen bytes.
      for (k = 0; k < plen; k++) begin
        j = plen - 1 - k;
        c = (j == 0) ? b : window[j - 1];
        if (ascii_lower(pat[k]) != ascii_lower(c)) begin
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // An input item was accepted: update the window and queue its outputs.
    function void take_byte(logic [7:0] b);
      bit hit;
      int unsigned n;
      int unsigned k;
      edit_out_t r;
      hit = hit_with(b);
      for (k = WINDOW_BYTES - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = b;
      if (seen < WINDOW_BYTES) begin
        seen++;
      end
      n = 0;
      if (hit) begin
        n = (ins_len > INSERT_BYTES) ? INSERT_BYTES : ins_len;
        inserted = 1'b1;
      end
      r.value = b;
      r.last  = (n == 0);
      due.push_back(r);
      for (k = 0; k < n; k++) begin
        r.value = ins[k];
        r.last  = (k + 1 == n);
        due.push_back(r);
      end
    endfunction

    // An output item was accepted: compare it with the oldest expectation.
    function void check_out(logic [7:0] ob, logic last);
      edit_out_t want;
      if (due.size() == 0) begin
        $error("out_byte %02h run_last %0b arrived with nothing expected", ob, last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (ob !== want.value) begin
        $error("out_byte: expected %02h, actual %02h", want.value, ob);
        errors++;
      end
      if (last !== want.last) begin
        $error("run_last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

endpackage

// ----- dv/stream_pattern_insert_tb.sv -----
// Testbench top: drives byte streams and register settings and checks the edited stream.
module stream_pattern_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 5;
  localparam int STALL_CYCLES = 80;
  localparam int GAP_PERCENT  = 6;

  localparam logic [7:0] CORNER_BYTES [14] = '{
    8'h00, 8'hFF, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40,
    8'h60, 8'h5B, 8'h7B, 8'h80, 8'h7F, 8'h55, 8'hAA
  };

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write;
  logic [spins_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [spins_pkg::CFG_DATA_W-1:0]  cfg_data;

  spins_in_if  rx_ch();
  spins_out_if tx_ch();

  spins_tb_pkg::edit_checker sb;
  bit gaps_on     = 1'b1;
  int stall_asked = 0;
  int stall_given = 0;
  int stall_left  = 0;
  int bytes_in    = 0;

  stream_pattern_insert i_dut (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_ch),
    .tx       (tx_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Output side: random ready, with one long hold-off when asked for.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      tx_ch.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_given != stall_asked) begin
      tx_ch.ready <= 1'b0;
      stall_left  <= STALL_CYCLES - 1;
      stall_given <= stall_asked;
    end else begin
      tx_ch.ready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
    end
  end

  // Every accepted output item is checked against the prediction.
  always @(posedge clk) begin
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      sb.check_out(tx_ch.out_byte, tx_ch.run_last);
    end
  end

  // Offer one byte, with an occasional gap before it, and wait for acceptance.
  task automatic send_byte(logic [7:0] b);
    if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      @(negedge clk);
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(2)) @(negedge clk);
    end
    @(negedge clk);
    rx_ch.valid     <= 1'b1;
    rx_ch.data_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sb.take_byte(b);
    bytes_in++;
  endtask

  // Before the insertion is due, re-roll any byte that would complete the pattern.
  task automatic send_no_hit(logic [7:0] b);
    logic [7:0] v;
    v = b;
    while (sb.hit_with(v)) v = 8'($urandom_range(255));
    send_byte(v);
  endtask

  task automatic write_reg(spins_pkg::cfg_reg_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stop offering items and wait until every expected output has come out.
  task automatic settle();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Pattern bytes lean toward letters and the punctuation next to them.
  function automatic logic [7:0] pick_pattern_byte();
    logic [7:0] c;
    case ($urandom_range(3))
      0, 1: c = 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(1) ? 8'h20 : 8'h00);
      2: c = ($urandom_range(1) ? 8'h40 : 8'h5B) ^ ($urandom_range(1) ? 8'h20 : 8'h00);
      default: c = 8'($urandom_range(255));
    endcase
    return c;
  endfunction

  function automatic logic [63:0] pattern_word();
    logic [63:0] w;
    int k;
    for (k = 0; k < 8; k++) w[8*k +: 8] = pick_pattern_byte();
    return w;
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] c);
    return (spins_tb_pkg::is_letter(c) && $urandom_range(1)) ? c ^ 8'h20 : c;
  endfunction

  // A byte that no longer matches: non-letters differ by the case bit only.
  function automatic logic [7:0] spoil(logic [7:0] c);
    logic [7:0] r;
    r = c ^ 8'h20;
    if (spins_tb_pkg::ascii_lower(r) == spins_tb_pkg::ascii_lower(c)) begin
      r = c ^ (8'h01 << $urandom_range(4));
    end
    return r;
  endfunction

  task automatic program_all(logic [63:0] plen, logic [63:0] lo, logic [63:0] hi,
                             logic [63:0] ilen);
    write_reg(spins_pkg::REG_PATTERN_LENGTH, plen);
    write_reg(spins_pkg::REG_PATTERN_LOW, lo);
    write_reg(spins_pkg::REG_PATTERN_HIGH, hi);
    write_reg(spins_pkg::REG_INSERT_LENGTH, ilen);
    write_reg(spins_pkg::REG_INSERT_WORD_0, rand_word());
    write_reg(spins_pkg::REG_INSERT_WORD_1, rand_word());
    write_reg(spins_pkg::REG_INSERT_WORD_2, rand_word());
    write_reg(spins_pkg::REG_INSERT_WORD_3, rand_word());
  endtask

  // Send the configured pattern in stream order, letters in random case,
  // with one byte spoiled when a near miss is wanted.
  task automatic send_pattern(bit near_miss, bit guarded);
    int plen;
    int bad;
    int k;
    logic [7:0] c;
    plen = (sb.pat_len > spins_tb_pkg::WINDOW_BYTES) ? spins_tb_pkg::WINDOW_BYTES :
           sb.pat_len;
    if (plen == 0) begin
      return;
    end
    bad = $urandom_range(plen - 1);
    for (k = 0; k < plen; k++) begin
      c = vary_case(sb.pat[k]);
      if (near_miss && k == bad) begin
        c = spoil(c);
      end
      if (guarded) begin
        send_no_hit(c);
      end else begin
        send_byte(c);
      end
    end
  endtask

  // Near misses and noise under one setting, never a full match.
  task automatic near_miss_round(int budget);
    int start;
    start = bytes_in;
    while (bytes_in - start < budget) begin
      if ($urandom_range(9) < 6) begin
        send_pattern(1'b1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) send_no_hit(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    #1ms;
    $display("** stream_pattern_insert: FAILED **");
    $finish;
  end

  initial begin
    int k;
    int ilen;
    sb = new();
    rx_ch.valid     = 1'b0;
    rx_ch.data_byte = '0;
    tx_ch.ready     = 1'b0;
    cfg_write       = 1'b0;
    cfg_index       = spins_pkg::REG_PATTERN_LENGTH;
    cfg_data        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short history: a zero pattern of three bytes must not match the
    // unfilled window before three bytes have arrived.
    write_reg(spins_pkg::REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'h00);
    send_byte(8'h00);
    send_no_hit(8'h01);
    settle();

    // Matching switched off: field extremes and case pairs pass straight through.
    write_reg(spins_pkg::REG_PATTERN_LENGTH, 64'd0);
    for (k = 0; k < 14; k++) send_byte(CORNER_BYTES[k]);
    settle();

    // Pattern length above the window folds to sixteen, insert length to 32;
    // the bits above each length field are junk.
    program_all({$urandom, 27'($urandom), 5'd31}, pattern_word(), pattern_word(),
                {$urandom, 26'($urandom), 6'd63});
    near_miss_round(8);
    settle();

    // Longest pattern with every byte at the top value.
    program_all(64'd16, '1, '1, 64'd32);
    near_miss_round(8);
    settle();

    // Single-byte pattern.
    program_all(64'd1, pattern_word(), pattern_word(), 64'($urandom_range(1, 31)));
    near_miss_round(6);
    settle();

    program_all(64'($urandom_range(2, 15)), pattern_word(), pattern_word(), 64'd0);
    near_miss_round(6);
    settle();

    // The one insertion: empty, oversized or in-range insert length.
    case ($urandom_range(2))
      0: ilen = 0;
      1: ilen = $urandom_range(32, 63);
      default: ilen = $urandom_range(1, 31);
    endcase
    program_all(64'($urandom_range(1, 31)), pattern_word(), pattern_word(), 64'(ilen));
    repeat (3) send_no_hit(8'($urandom_range(255)));
    // Hold the output off while the pattern and more bytes keep coming.
    stall_asked++;
    send_pattern(1'b0, 1'b0);
    repeat (10) send_byte(8'($urandom_range(255)));
    settle();

    // After the insertion the pattern passes through untouched, with no gaps.
    gaps_on = 1'b0;
    repeat (2) begin
      send_pattern(1'b0, 1'b0);
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    end
    gaps_on = 1'b1;
    settle();

    // Register writes leave the insertion spent.
    write_reg(spins_pkg::REG_INSERT_LENGTH, 64'd5);
    write_reg(spins_pkg::REG_PATTERN_LENGTH, 64'd2);
    repeat (2) send_pattern(1'b0, 1'b0);
    repeat (5) send_byte(8'($urandom_range(255)));
    settle();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** stream_pattern_insert: PASSED **");
    end else begin
      $display("** stream_pattern_insert: FAILED **");
    end
    $finish;
  end

endmodule

// ----- stream_pattern_insert.f -----
hdl/spins_pkg.sv
hdl/spins_if.sv
hdl/spins_cell.sv
hdl/spins_emit.sv
hdl/stream_pattern_insert.sv
dv/spins_tb_pkg.sv
dv/stream_pattern_insert_tb.sv
